// ----- rtl/gof_pkg.sv -----
package gof_pkg;

  // fixed field widths
  localparam int COORD_W = 20;
  localparam int FONT_W  = 16;
  localparam int SCALE_W = 24;

  localparam logic [COORD_W-1:0] COORD_MAX   = '1;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

  // near-flat test: 5 * |dy| <= one pixel, i.e. |dy| <= 0.2 pixel
  localparam int FLAT_DIV = 5;
  localparam int FLAT_W   = COORD_W + 3;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_SCALE    = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } xy_t;

  // scaled outline point
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   on_curve;
    logic   contour_end;
  } spoint_t;

  // one line or one quadratic curve to be broken into segments
  typedef struct packed {
    logic curve;
    logic last;
    xy_t  p0;
    xy_t  c;
    xy_t  p2;
  } job_t;

  // side data of one segment in flight through the divider
  typedef struct packed {
    logic first;
    logic last;
    logic lit;
    xy_t  start;
    xy_t  lit_end;
  } elem_t;

endpackage

// ----- rtl/gof_point_if.sv -----
interface gof_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [gof_pkg::FONT_W-1:0]   point_x;
  logic signed [gof_pkg::FONT_W-1:0]   point_y;
  logic                                on_curve;
  logic                                contour_end;

  modport source (output valid, point_x, point_y, on_curve, contour_end, input ready);
  modport sink   (input valid, point_x, point_y, on_curve, contour_end, output ready);
endinterface

// ----- rtl/gof_seg_if.sv -----
interface gof_seg_if;
  logic                         valid;
  logic                         ready;
  logic [gof_pkg::COORD_W-1:0]  seg_start_x;
  logic [gof_pkg::COORD_W-1:0]  seg_start_y;
  logic [gof_pkg::COORD_W-1:0]  seg_end_x;
  logic [gof_pkg::COORD_W-1:0]  seg_end_y;
  logic                         is_vertical;
  logic                         is_flat;
  logic                         last;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  is_vertical, is_flat, last, input ready);
  modport sink   (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  is_vertical, is_flat, last, output ready);
endinterface

// ----- rtl/gof_scale.sv -----
module gof_scale #(
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  gof_point_if.sink                         pt_in,
  input  logic signed [gof_pkg::FONT_W-1:0] origin_x,
  input  logic signed [gof_pkg::FONT_W-1:0] origin_y,
  input  logic [gof_pkg::SCALE_W-1:0]       scale_recip,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gof_pkg::spoint_t                  out_pt
);

  localparam int PROD_W = gof_pkg::FONT_W + gof_pkg::SCALE_W;
  localparam int SHIFT  = 16 - FRAC_BITS;
  localparam logic [PROD_W:0] RND = (PROD_W+1)'(1) << (15 - FRAC_BITS);

  logic                              raw_valid;
  logic signed [gof_pkg::FONT_W-1:0] raw_x;
  logic signed [gof_pkg::FONT_W-1:0] raw_y;
  logic                              raw_on;
  logic                              raw_end;
  logic                              raw_load;
  logic                              s1_load;

  // shift by origin, scale, round half up, clamp
  function automatic gof_pkg::coord_t scale_coord(
    logic signed [gof_pkg::FONT_W-1:0] p,
    logic signed [gof_pkg::FONT_W-1:0] org,
    logic [gof_pkg::SCALE_W-1:0]       rcp
  );
    logic signed [gof_pkg::FONT_W:0] d;
    logic [PROD_W-1:0]               prod;
    logic [PROD_W:0]                 v;
    d    = (gof_pkg::FONT_W+1)'(p) - (gof_pkg::FONT_W+1)'(org);
    prod = PROD_W'(d[gof_pkg::FONT_W-1:0]) * PROD_W'(rcp);
    v    = ({1'b0, prod} + RND) >> SHIFT;
    if (d <= 0) begin
      return '0;
    end else if (v > (PROD_W+1)'(gof_pkg::COORD_MAX)) begin
      return gof_pkg::COORD_MAX;
    end else begin
      return v[gof_pkg::COORD_W-1:0];
    end
  endfunction

  // handshake between the raw and scaled registers
  assign s1_load     = raw_valid && (!out_valid || out_ready);
  assign pt_in.ready = !raw_valid || s1_load;
  assign raw_load    = pt_in.valid && pt_in.ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (raw_load) begin
        raw_valid <= 1'b1;
      end else if (s1_load) begin
        raw_valid <= 1'b0;
      end
      if (s1_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // raw point register
  always_ff @(posedge clk) begin
    if (raw_load) begin
      raw_x   <= pt_in.point_x;
      raw_y   <= pt_in.point_y;
      raw_on  <= pt_in.on_curve;
      raw_end <= pt_in.contour_end;
    end
  end

  // scaled point register
  always_ff @(posedge clk) begin
    if (s1_load) begin
      out_pt.x           <= scale_coord(raw_x, origin_x, scale_recip);
      out_pt.y           <= scale_coord(raw_y, origin_y, scale_recip);
      out_pt.on_curve    <= raw_on;
      out_pt.contour_end <= raw_end;
    end
  end

endmodule

// ----- rtl/gof_bez_div.sv -----
module gof_bez_div #(
  parameter int NN   = 25,
  parameter int NUMW = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [NUMW-1:0]    num_x,
  input  logic [NUMW-1:0]    num_y,
  output logic               out_valid,
  output gof_pkg::xy_t       q
);

  localparam int MW = NUMW + 1;
  localparam int PW = NUMW + MW;
  localparam logic [MW-1:0]   RECIP = MW'((64'd1 << NUMW) / NN);
  localparam logic [NUMW-1:0] DIV   = NUMW'(NN);

  logic            v1;
  logic [PW-1:0]   prod_x;
  logic [PW-1:0]   prod_y;
  logic [NUMW-1:0] num1_x;
  logic [NUMW-1:0] num1_y;
  logic [NUMW-1:0] q0_x;
  logic [NUMW-1:0] q0_y;
  logic [NUMW-1:0] rem_x;
  logic [NUMW-1:0] rem_y;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // reciprocal multiply, quotient low by at most one
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= PW'(num_x) * PW'(RECIP);
      prod_y <= PW'(num_y) * PW'(RECIP);
      num1_x <= num_x;
      num1_y <= num_y;
    end
  end

  // remainder and single correction step
  always_comb begin
    q0_x  = NUMW'(prod_x >> NUMW);
    q0_y  = NUMW'(prod_y >> NUMW);
    rem_x = num1_x - q0_x * DIV;
    rem_y = num1_y - q0_y * DIV;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.x <= q0_x[gof_pkg::COORD_W-1:0] + gof_pkg::COORD_W'(rem_x >= DIV);
      q.y <= q0_y[gof_pkg::COORD_W-1:0] + gof_pkg::COORD_W'(rem_y >= DIV);
    end
  end

`ifndef SYNTHESIS
  // the reciprocal estimate never misses by more than one
  a_rem_x: assert property (@(posedge clk) disable iff (rst)
    v1 |-> rem_x < (DIV << 1))
    else $error("x quotient estimate off by more than one");
  a_rem_y: assert property (@(posedge clk) disable iff (rst)
    v1 |-> rem_y < (DIV << 1))
    else $error("y quotient estimate off by more than one");
  a_rem_fix: assert property (@(posedge clk) disable iff (rst)
    v1 && rem_x >= DIV |-> q0_x[gof_pkg::COORD_W-1:0] != gof_pkg::COORD_MAX)
    else $error("quotient correction overflows the coordinate");
`endif

endmodule

// ----- rtl/glyph_outline_flattener_top.sv -----
// Glyph outline flattener: outline points in, straight pixel-space segments out.
// pt_in takes one point per beat (font-unit x/y, on-curve, contour-end). seg_out
// gives one segment per beat in unsigned Q12.8 pixels with vertical, near-flat
// and last flags; last marks the final segment caused by a point.
// The APB port writes origin_x, origin_y and scale_recip at byte 0, 4 and 8;
// write it only while no point is in flight.
// The first segment of a point passes the input register, scaler multiply, walk,
// segment sequencer, two divider stages and the output register.
// Throughput: the segment sequencer makes one segment per cycle unless seg_out
// stalls. A straight edge gives one segment, a curve point CURVE_STEPS segments
// and a point that closes a curve contour up to 2*CURVE_STEPS; some give none.
// Points take the scaling in effect when they pass from input to scaler register.
// Reset (synchronous) empties every stage, sets origin to 0 and scale_recip to 1.0,
// and starts a new contour. When seg_out stalls the whole segment pipeline holds;
// pt_in takes points until job queue, input and scaler registers are full.
module glyph_outline_flattener_top #(
  parameter int CURVE_STEPS = 5,
  parameter int FRAC_BITS   = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  gof_point_if.sink                          pt_in,
  gof_seg_if.source                          seg_out,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gof_pkg::PADDR_W-1:0]        paddr,
  input  logic [gof_pkg::PDATA_W-1:0]        pwdata,
  output logic [gof_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  localparam int N    = CURVE_STEPS;
  localparam int NN   = N * N;
  localparam int KW   = $clog2(N + 1);
  localparam int NUMW = $clog2(NN) + gof_pkg::COORD_W;
  localparam int AW   = NUMW + 5;

  // numerator of curve point 1, its first and second differences
  localparam logic signed [AW-1:0] C1A  = AW'((N - 1) * (N - 1));
  localparam logic signed [AW-1:0] C1C  = AW'(2 * (N - 1));
  localparam logic signed [AW-1:0] HALF = AW'(NN / 2);
  localparam logic signed [AW-1:0] D1A  = AW'(3 - 2 * N);
  localparam logic signed [AW-1:0] D1C  = AW'(2 * (N - 3));
  localparam logic signed [AW-1:0] D1B  = AW'(3);

  // walk phases
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ON    = 2'd1;
  localparam logic [1:0] PH_CTRL  = 2'd2;

  // configuration registers
  logic signed [gof_pkg::FONT_W-1:0] origin_x;
  logic signed [gof_pkg::FONT_W-1:0] origin_y;
  logic [gof_pkg::SCALE_W-1:0]       scale_recip;
  logic                              cfg_wr;

  // scaled point
  logic             sp_valid;
  gof_pkg::spoint_t sp;

  // walk state
  logic [1:0]       walk_phase;
  logic [1:0]       walk_phase_next;
  gof_pkg::xy_t     pen;
  gof_pkg::xy_t     pen_next;
  gof_pkg::xy_t     prev;
  gof_pkg::xy_t     start;
  logic             start_on_curve;
  gof_pkg::xy_t     pt;
  gof_pkg::xy_t     start_cur;
  logic             start_on_cur;
  gof_pkg::xy_t     mid_prev;
  gof_pkg::xy_t     mid_start;
  logic             ja_valid;
  logic             jb_valid;
  gof_pkg::job_t    ja;
  gof_pkg::job_t    jb;
  logic             walk_fire;

  // job queue
  logic             jq0_valid;
  logic             jq1_valid;
  gof_pkg::job_t    jq0;
  gof_pkg::job_t    jq1;
  logic             q_space;

  // segment sequencer
  logic                   cur_active;
  gof_pkg::job_t          cur_job;
  logic [KW-1:0]          cur_k;
  logic signed [AW-1:0]   num_x;
  logic signed [AW-1:0]   num_y;
  logic signed [AW-1:0]   d1_x;
  logic signed [AW-1:0]   d1_y;
  logic signed [AW-1:0]   d2_x;
  logic signed [AW-1:0]   d2_y;
  logic signed [AW-1:0]   num1_x;
  logic signed [AW-1:0]   num1_y;
  logic signed [AW-1:0]   d1s_x;
  logic signed [AW-1:0]   d1s_y;
  logic signed [AW-1:0]   d2s_x;
  logic signed [AW-1:0]   d2s_y;
  logic                   cur_final;
  logic                   seq_load;
  logic                   adv;

  // divider side data and output stage
  gof_pkg::elem_t   el0;
  gof_pkg::elem_t   el1;
  gof_pkg::elem_t   el2;
  logic             dq_valid;
  gof_pkg::xy_t     dq;
  gof_pkg::xy_t     last_end;
  gof_pkg::xy_t     seg_start;
  gof_pkg::xy_t     seg_end;
  gof_pkg::coord_t  dy;
  logic [gof_pkg::FLAT_W-1:0] dy5;
  logic             out_valid;
  gof_pkg::xy_t     out_start;
  gof_pkg::xy_t     out_end;
  logic             out_vert;
  logic             out_flat;
  logic             out_last;

  function automatic gof_pkg::xy_t midpt(gof_pkg::xy_t a, gof_pkg::xy_t b);
    logic [gof_pkg::COORD_W:0] sx;
    logic [gof_pkg::COORD_W:0] sy;
    gof_pkg::xy_t              m;
    sx  = {1'b0, a.x} + {1'b0, b.x} + (gof_pkg::COORD_W+1)'(1);
    sy  = {1'b0, a.y} + {1'b0, b.y} + (gof_pkg::COORD_W+1)'(1);
    m.x = sx[gof_pkg::COORD_W:1];
    m.y = sy[gof_pkg::COORD_W:1];
    return m;
  endfunction

  function automatic logic signed [AW-1:0] ext(gof_pkg::coord_t v);
    return $signed({{(AW-gof_pkg::COORD_W){1'b0}}, v});
  endfunction

  // apb register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= '0;
      origin_y    <= '0;
      scale_recip <= gof_pkg::SCALE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[gof_pkg::PADDR_W-1:2])
        gof_pkg::REG_ORIGIN_X: origin_x    <= pwdata[gof_pkg::FONT_W-1:0];
        gof_pkg::REG_ORIGIN_Y: origin_y    <= pwdata[gof_pkg::FONT_W-1:0];
        gof_pkg::REG_SCALE:    scale_recip <= pwdata[gof_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[gof_pkg::PADDR_W-1:2])
      gof_pkg::REG_ORIGIN_X: prdata = gof_pkg::PDATA_W'(origin_x);
      gof_pkg::REG_ORIGIN_Y: prdata = gof_pkg::PDATA_W'(origin_y);
      gof_pkg::REG_SCALE:    prdata = gof_pkg::PDATA_W'(scale_recip);
      default:               prdata = '0;
    endcase
  end

  // input register and scaling
  gof_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .pt_in       (pt_in),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .scale_recip (scale_recip),
    .out_valid   (sp_valid),
    .out_ready   (q_space),
    .out_pt      (sp)
  );

  // pipeline and queue control
  assign adv       = !out_valid || seg_out.ready;
  assign cur_final = cur_active && (!cur_job.curve || cur_k == KW'(N));
  assign seq_load  = adv && jq0_valid && (!cur_active || cur_final);
  assign q_space   = !jq0_valid || (seq_load && !jq1_valid);
  assign walk_fire = sp_valid && q_space;

  // outline walk: turns one point into up to two jobs
  always_comb begin
    pt.x            = sp.x;
    pt.y            = sp.y;
    start_cur       = (walk_phase == PH_START) ? pt : start;
    start_on_cur    = (walk_phase == PH_START) ? sp.on_curve : start_on_curve;
    mid_prev        = midpt(prev, pt);
    mid_start       = midpt(start_cur, pt);
    walk_phase_next = walk_phase;
    pen_next        = pen;
    ja_valid        = 1'b0;
    jb_valid        = 1'b0;
    ja.curve        = 1'b0;
    ja.last         = !sp.contour_end;
    ja.p0           = pen;
    ja.c            = prev;
    ja.p2           = pt;
    jb.curve        = 1'b0;
    jb.last         = 1'b1;
    jb.p0           = pt;
    jb.c            = pt;
    jb.p2           = start_cur;
    unique case (walk_phase)
      PH_START: begin
        pen_next        = pt;
        walk_phase_next = PH_ON;
      end
      PH_ON: begin
        if (sp.on_curve) begin
          ja_valid = 1'b1;
          pen_next = pt;
        end else begin
          walk_phase_next = PH_CTRL;
        end
      end
      default: begin
        ja_valid = 1'b1;
        ja.curve = 1'b1;
        if (sp.on_curve) begin
          pen_next        = pt;
          walk_phase_next = PH_ON;
        end else begin
          ja.p2           = mid_prev;
          pen_next        = mid_prev;
          walk_phase_next = PH_CTRL;
        end
      end
    endcase
    // contour closure
    if (sp.contour_end) begin
      jb_valid = 1'b1;
      if (walk_phase_next == PH_CTRL) begin
        jb.curve = 1'b1;
        jb.p0    = pen_next;
        jb.p2    = start_on_cur ? start_cur : mid_start;
      end
      walk_phase_next = PH_START;
    end
  end

  // walk state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_phase     <= PH_START;
      pen            <= '0;
      prev           <= '0;
      start          <= '0;
      start_on_curve <= 1'b0;
    end else if (walk_fire) begin
      walk_phase <= walk_phase_next;
      pen        <= pen_next;
      prev       <= pt;
      if (walk_phase == PH_START) begin
        start          <= pt;
        start_on_curve <= sp.on_curve;
      end
    end
  end

  // two-entry job queue
  always_ff @(posedge clk) begin
    if (rst) begin
      jq0_valid <= 1'b0;
      jq1_valid <= 1'b0;
    end else if (walk_fire) begin
      jq0_valid <= ja_valid || jb_valid;
      jq1_valid <= ja_valid && jb_valid;
    end else if (seq_load) begin
      jq0_valid <= jq1_valid;
      jq1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_fire) begin
      jq0 <= ja_valid ? ja : jb;
      jq1 <= jb;
    end else if (seq_load) begin
      jq0 <= jq1;
    end
  end

  // curve setup from the queue head
  always_comb begin
    num1_x = C1A * ext(jq0.p0.x) + C1C * ext(jq0.c.x) + ext(jq0.p2.x) + HALF;
    num1_y = C1A * ext(jq0.p0.y) + C1C * ext(jq0.c.y) + ext(jq0.p2.y) + HALF;
    d1s_x  = D1A * ext(jq0.p0.x) + D1C * ext(jq0.c.x) + D1B * ext(jq0.p2.x);
    d1s_y  = D1A * ext(jq0.p0.y) + D1C * ext(jq0.c.y) + D1B * ext(jq0.p2.y);
    d2s_x  = (ext(jq0.p0.x) <<< 1) - (ext(jq0.c.x) <<< 2) + (ext(jq0.p2.x) <<< 1);
    d2s_y  = (ext(jq0.p0.y) <<< 1) - (ext(jq0.c.y) <<< 2) + (ext(jq0.p2.y) <<< 1);
  end

  // sequencer: one segment a cycle while adv; numerators by forward differences
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_active <= 1'b0;
    end else if (adv && (!cur_active || cur_final)) begin
      cur_active <= jq0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_load) begin
      cur_job <= jq0;
      cur_k   <= KW'(1);
      num_x   <= num1_x;
      num_y   <= num1_y;
      d1_x    <= d1s_x;
      d1_y    <= d1s_y;
      d2_x    <= d2s_x;
      d2_y    <= d2s_y;
    end else if (adv && cur_active && !cur_final) begin
      cur_k <= cur_k + KW'(1);
      num_x <= num_x + d1_x;
      num_y <= num_y + d1_y;
      d1_x  <= d1_x + d2_x;
      d1_y  <= d1_y + d2_y;
    end
  end

  // side data of the segment leaving the sequencer
  always_comb begin
    el0.first   = (cur_k == KW'(1));
    el0.last    = cur_job.last && cur_final;
    el0.lit     = cur_final;
    el0.start   = cur_job.p0;
    el0.lit_end = cur_job.p2;
  end

  // division by steps squared, round half up
  gof_bez_div #(
    .NN   (NN),
    .NUMW (NUMW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (cur_active),
    .num_x     (num_x[NUMW-1:0]),
    .num_y     (num_y[NUMW-1:0]),
    .out_valid (dq_valid),
    .q         (dq)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      el1 <= el0;
      el2 <= el1;
    end
  end

  // segment assembly and flags
  always_comb begin
    seg_start = el2.first ? el2.start : last_end;
    seg_end   = el2.lit ? el2.lit_end : dq;
    dy        = (seg_end.y > seg_start.y) ? seg_end.y - seg_start.y
                                          : seg_start.y - seg_end.y;
    dy5       = gof_pkg::FLAT_W'(dy) * gof_pkg::FLAT_W'(gof_pkg::FLAT_DIV);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dq_valid) begin
      last_end  <= seg_end;
      out_start <= seg_start;
      out_end   <= seg_end;
      out_vert  <= (seg_end.x == seg_start.x);
      out_flat  <= (dy5 <= (gof_pkg::FLAT_W'(1) << FRAC_BITS));
      out_last  <= el2.last;
    end
  end

  assign seg_out.valid       = out_valid;
  assign seg_out.seg_start_x = out_start.x;
  assign seg_out.seg_start_y = out_start.y;
  assign seg_out.seg_end_x   = out_end.x;
  assign seg_out.seg_end_y   = out_end.y;
  assign seg_out.is_vertical = out_vert;
  assign seg_out.is_flat     = out_flat;
  assign seg_out.last        = out_last;

`ifndef SYNTHESIS
  // the queue fills from its head
  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    jq1_valid |-> jq0_valid)
    else $error("job queue tail valid without head");
  // curve step stays within 1..CURVE_STEPS
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cur_active |-> (cur_k >= KW'(1)) && (cur_k <= KW'(N)))
    else $error("curve step out of range");
  // a straight job is done in its first step
  a_line_once: assert property (@(posedge clk) disable iff (rst)
    cur_active && !cur_job.curve |-> cur_k == KW'(1))
    else $error("straight job ran past its first step");
  // a new point is walked only when the queue tail is empty
  a_walk_space: assert property (@(posedge clk) disable iff (rst)
    walk_fire |-> !jq1_valid)
    else $error("point walked into a full job queue");
`endif

endmodule
